// ===== src/bwlf_pkg.sv =====
package bwlf_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;
  localparam int SIZE_RESET         = 1024;

  localparam int OP_W        = 2;
  localparam int TIDX_W      = 3;
  localparam int TWORD_W     = 64;
  localparam int TABLE_WORDS = 8;
  localparam int BIT_SEL_W   = 6;
  localparam int WIN_W       = 9;
  localparam int LIT_W       = 21;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_PAD   = 2'd2
  } op_e_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 2'd2;

  // One word handed from the front to the back: a table load or a finished window.
  typedef struct packed {
    logic               is_load;
    logic [TIDX_W-1:0]  table_index;
    logic [TWORD_W-1:0] table_word;
    logic [WIN_W-1:0]   win_idx;
    logic               last;
  } qentry_t;

endpackage

// ===== src/binary_window_lookup_filter.sv =====
// Output: a filtered pixel leaves once the item one row plus one pixel later is taken.
// Throughput: one item per cycle unless stalled; the 3x3 window moves one column per pixel, fed
// by a line memory of MAX_WIDTH two-bit entries with one registered read and one write per cycle.
// A short queue parts the window front end from the table lookup and the output register.
// Reset (rst, synchronous) clears control state, positions, window, count and table;
// the line memory is not cleared, as its bits outside the current frame are never used.
module binary_window_lookup_filter #(
  parameter int MAX_WIDTH  = bwlf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = bwlf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bwlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwlf_pkg::CFG_W-1:0]        cfg_word,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bwlf_pkg::OP_W-1:0]         operation,
  input  logic [bwlf_pkg::TIDX_W-1:0]       table_index,
  input  logic [bwlf_pkg::TWORD_W-1:0]      table_word,
  input  logic                              pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pixel_out,
  output logic                              last_of_frame,
  output logic [bwlf_pkg::LIT_W-1:0]        lit_count,
  output logic                              next_background
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WidthReset  = (bwlf_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH :
                                                                    bwlf_pkg::SIZE_RESET;
  localparam int HeightReset = (bwlf_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
                                                                     bwlf_pkg::SIZE_RESET;

  function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] maxv);
    if (v == '0) begin
      return 32'd1;
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  logic [WW-1:0] frame_width;
  logic [HW-1:0] frame_height;
  logic background, cfg_accept, restart;
  logic push, pop, head_valid;
  bwlf_pkg::qentry_t push_entry, head;
  logic [bwlf_pkg::QLEVEL_W-1:0] queue_level;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index)
      bwlf_pkg::CFG_FRAME_WIDTH:  restart = cfg_accept;
      bwlf_pkg::CFG_FRAME_HEIGHT: restart = cfg_accept;
      default:                    restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WW'(WidthReset);
      frame_height <= HW'(HeightReset);
      background   <= 1'b0;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        bwlf_pkg::CFG_FRAME_WIDTH:
          frame_width <= WW'(clamp_size(32'(cfg_word), 32'(MAX_WIDTH)));
        bwlf_pkg::CFG_FRAME_HEIGHT:
          frame_height <= HW'(clamp_size(32'(cfg_word), 32'(MAX_HEIGHT)));
        bwlf_pkg::CFG_BACKGROUND:
          background <= cfg_word[0];
        default: ;
      endcase
    end
  end

  bwlf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .background   (background),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .table_index  (table_index),
    .table_word   (table_word),
    .pixel_in     (pixel_in),
    .queue_level  (queue_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  bwlf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (queue_level)
  );

  bwlf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .background      (background),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pixel_out       (pixel_out),
    .last_of_frame   (last_of_frame),
    .lit_count       (lit_count),
    .next_background (next_background)
  );

endmodule

// ===== src/bwlf_front.sv =====
module bwlf_front #(
  parameter int MAX_WIDTH  = bwlf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = bwlf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        frame_width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       frame_height,
  input  logic                                  background,
  input  logic                                  restart,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bwlf_pkg::OP_W-1:0]             operation,
  input  logic [bwlf_pkg::TIDX_W-1:0]           table_index,
  input  logic [bwlf_pkg::TWORD_W-1:0]          table_word,
  input  logic                                  pixel_in,
  input  logic [bwlf_pkg::QLEVEL_W-1:0]         queue_level,
  output logic                                  push,
  output bwlf_pkg::qentry_t                     push_entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int LW = bwlf_pkg::QLEVEL_W + 1;
  localparam int NW = bwlf_pkg::WIN_W;

  localparam logic [NW-1:0] COL_LEFT   = 9'h124;
  localparam logic [NW-1:0] COL_RIGHT  = 9'h049;
  localparam logic [NW-1:0] ROW_TOP    = 9'h1C0;
  localparam logic [NW-1:0] ROW_BOTTOM = 9'h007;
  localparam logic [NW-1:0] KEEP_SHIFT = 9'h1B6;

  function automatic logic [NW-1:0] fill_bits(input logic [NW-1:0] w, input logic [NW-1:0] m,
                                              input logic bg);
    return bg ? (w | m) : (w & ~m);
  endfunction

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic accept, item_pixel, item_load;
  logic [RW-1:0] height_r, rq;
  logic [WW-1:0] width_m1, col_inc;
  logic [CW-1:0] cq;
  logic c_zero, emit, in_frame, pix_val;
  logic at_left, at_right, at_top, at_bottom, at_last;

  // Stage 1 holds the item while its two line bits come out of the memory.
  logic s1_pixel, s1_load, s1_val, s1_emit, s1_last;
  logic s1_left, s1_right, s1_top, s1_bottom;
  logic [CW-1:0] s1_col;
  logic [bwlf_pkg::TIDX_W-1:0] s1_tidx;
  logic [bwlf_pkg::TWORD_W-1:0] s1_tword;

  // Each entry is {row two above, row one above} for one column.
  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] line_rd;
  logic [NW-1:0] window, win_shift, win_idx;

  // Credit check: the word in stage 1 always finds a free queue slot.
  assign in_stall = (LW'(queue_level) + LW'(s1_pixel | s1_load)) >= LW'(bwlf_pkg::QUEUE_DEPTH);
  assign accept = in_valid && !in_stall;
  assign item_pixel = accept && (operation == bwlf_pkg::OP_PIXEL ||
                                 operation == bwlf_pkg::OP_PAD);
  assign item_load = accept && operation == bwlf_pkg::OP_LOAD;

  assign height_r = RW'(frame_height);
  assign width_m1 = frame_width - WW'(1);
  assign col_inc  = WW'(col) + WW'(1);
  assign c_zero   = col == '0;
  assign rq       = c_zero ? row - RW'(2) : row - RW'(1);
  assign cq       = c_zero ? CW'(width_m1) : col - CW'(1);
  assign emit     = (row >= RW'(2) || (row == RW'(1) && !c_zero)) && rq < height_r;
  assign at_left   = cq == '0;
  assign at_right  = WW'(cq) == width_m1;
  assign at_top    = rq == '0;
  assign at_bottom = rq == height_r - RW'(1);
  assign at_last   = at_bottom && at_right;
  assign in_frame  = row < height_r;
  assign pix_val   = (operation == bwlf_pkg::OP_PIXEL && in_frame) ? pixel_in : background;

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (item_pixel) begin
      if (emit && at_last) begin
        col_next = '0;
        row_next = '0;
      end else if (col_inc >= frame_width) begin
        col_next = '0;
        row_next = row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      s1_pixel <= 1'b0;
      s1_load <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      s1_pixel <= item_pixel;
      s1_load <= item_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val    <= pix_val;
      s1_col    <= col;
      s1_emit   <= emit;
      s1_last   <= at_last;
      s1_left   <= at_left;
      s1_right  <= at_right;
      s1_top    <= at_top;
      s1_bottom <= at_bottom;
      s1_tidx   <= table_index;
      s1_tword  <= table_word;
    end
  end

  // When a one-pixel row revisits the column being written, take the new bits directly.
  always_ff @(posedge clk) begin
    if (item_pixel) begin
      if (s1_pixel && s1_col == col) begin
        line_rd <= {line_rd[0], s1_val};
      end else begin
        line_rd <= line_mem[col];
      end
    end
    if (s1_pixel) begin
      line_mem[s1_col] <= {line_rd[0], s1_val};
    end
  end

  assign win_shift = ((window << 1) & KEEP_SHIFT) |
                     {2'b00, line_rd[1], 2'b00, line_rd[0], 2'b00, s1_val};

  // Bits of stale rows and columns outside the frame are replaced here.
  always_comb begin
    win_idx = win_shift;
    if (s1_left) begin
      win_idx = fill_bits(win_idx, COL_LEFT, background);
    end
    if (s1_right) begin
      win_idx = fill_bits(win_idx, COL_RIGHT, background);
    end
    if (s1_top) begin
      win_idx = fill_bits(win_idx, ROW_TOP, background);
    end
    if (s1_bottom) begin
      win_idx = fill_bits(win_idx, ROW_BOTTOM, background);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_pixel) begin
      window <= win_shift;
    end
  end

  assign push = (s1_pixel && s1_emit) || s1_load;

  always_comb begin
    push_entry.is_load     = s1_load;
    push_entry.table_index = s1_tidx;
    push_entry.table_word  = s1_tword;
    push_entry.win_idx     = win_idx;
    push_entry.last        = s1_last;
  end

endmodule

// ===== src/bwlf_queue.sv =====
module bwlf_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bwlf_pkg::qentry_t             push_entry,
  input  logic                          pop,
  output bwlf_pkg::qentry_t             head,
  output logic                          head_valid,
  output logic [bwlf_pkg::QLEVEL_W-1:0] level
);

  localparam int DEPTH = bwlf_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int QW = bwlf_pkg::QLEVEL_W;

  bwlf_pkg::qentry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [QW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + QW'(1);
        2'b01:   count <= count - QW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign head = entries[rd_ptr];
  assign head_valid = count != '0;
  assign level = count;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < QW'(DEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");
`endif

endmodule

// ===== src/bwlf_back.sv =====
module bwlf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           background,
  input  bwlf_pkg::qentry_t              head,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pixel_out,
  output logic                           last_of_frame,
  output logic [bwlf_pkg::LIT_W-1:0]     lit_count,
  output logic                           next_background
);

  localparam int NW = bwlf_pkg::WIN_W;
  localparam int LW = bwlf_pkg::LIT_W;
  localparam int TW = bwlf_pkg::TWORD_W;
  localparam int SW = bwlf_pkg::BIT_SEL_W;

  logic [TW-1:0] lut [bwlf_pkg::TABLE_WORDS];
  logic [LW-1:0] lit_total, lit_sum;
  logic out_free, pop_pixel, lut_bit, bg_bit;

  assign out_free  = !out_valid || !out_stall;
  assign pop       = head_valid && (head.is_load || out_free);
  assign pop_pixel = pop && !head.is_load;

  assign lut_bit = lut[head.win_idx[NW-1:SW]][head.win_idx[SW-1:0]];
  assign bg_bit  = background ? lut[bwlf_pkg::TABLE_WORDS-1][TW-1] : lut[0][0];
  assign lit_sum = lit_total + LW'(lut_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bwlf_pkg::TABLE_WORDS; i++) begin
        lut[i] <= '0;
      end
    end else if (pop && head.is_load) begin
      lut[head.table_index] <= head.table_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lit_total <= '0;
    end else begin
      if (pop_pixel) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        lit_total <= '0;
      end else if (pop_pixel) begin
        lit_total <= head.last ? '0 : lit_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      pixel_out       <= lut_bit;
      last_of_frame   <= head.last;
      lit_count       <= head.last ? lit_sum : '0;
      next_background <= head.last ? bg_bit : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_summary_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_frame |-> lit_count == '0 && !next_background)
    else $error("frame summary on a word that does not end the frame");
`endif

endmodule
